@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/d8fd_pkg.sv @@
package d8fd_pkg;

	localparam int MAX_WIDTH      = 4096;
	localparam int ELEV_BITS      = 16;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int FWIDTH_BITS    = 13;
	localparam int ROW_BITS       = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;

	localparam int WEIGHT_BITS = 16;
	localparam int SCORE_BITS  = ELEV_BITS + WEIGHT_BITS;
	localparam logic [WEIGHT_BITS-1:0] DIAG_WEIGHT = 16'd46341;

	localparam int NUM_DIRS    = 8;
	localparam int NUM_LANES   = 4;
	localparam int MAX_RESULTS = 4;
	localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	localparam logic signed [3:0] DIR_E    = 4'sd0;
	localparam logic signed [3:0] DIR_W    = 4'sd1;
	localparam logic signed [3:0] DIR_S    = 4'sd2;
	localparam logic signed [3:0] DIR_N    = 4'sd3;
	localparam logic signed [3:0] DIR_SE   = 4'sd4;
	localparam logic signed [3:0] DIR_SW   = 4'sd5;
	localparam logic signed [3:0] DIR_NE   = 4'sd6;
	localparam logic signed [3:0] DIR_NW   = 4'sd7;
	localparam logic signed [3:0] DIR_NONE = -4'sd1;

	localparam int DIR_DC [NUM_DIRS] = '{1, -1, 0, 0, 1, -1, 1, -1};
	localparam int DIR_DR [NUM_DIRS] = '{0, 0, 1, -1, 1, 1, -1, -1};

	// window position of each lane's center pixel
	localparam int CTR_ROW [NUM_LANES] = '{1, 1, 2, 2};
	localparam int CTR_COL [NUM_LANES] = '{1, 2, 1, 2};

	typedef logic signed [ELEV_BITS-1:0] elev_t;
	typedef elev_t [2:0][2:0] window_t;
	typedef elev_t [NUM_DIRS-1:0] nbr_t;
	typedef logic [ELEV_BITS-1:0] drop_t;

	typedef struct packed {
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic                last_col;
		logic                last_row;
	} meta_t;

	typedef struct packed {
		logic signed [3:0]   direction;
		logic [COL_BITS-1:0] column;
		logic [ROW_BITS-1:0] row;
		logic                frame_last;
	} result_t;

endpackage

@@ sv/d8fd_ram.sv @@
module d8fd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/d8fd_front.sv @@
module d8fd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                write_enable,
	input  logic [d8fd_pkg::CFG_INDEX_BITS-1:0] write_index,
	input  logic [d8fd_pkg::CFG_DATA_BITS-1:0]  write_data,
	input  logic                                accept,
	input  d8fd_pkg::elev_t                     elevation,
	output logic [d8fd_pkg::CNT_BITS-1:0]       result_count,
	output logic                                valid_s2,
	output d8fd_pkg::meta_t                     meta_s2,
	output d8fd_pkg::window_t                   window_q
);

	logic [d8fd_pkg::FWIDTH_BITS-1:0] frame_width_q;
	logic [d8fd_pkg::ROW_BITS-1:0]    frame_height_q;
	logic [d8fd_pkg::COL_BITS-1:0]    column_q;
	logic [d8fd_pkg::ROW_BITS-1:0]    row_q;
	logic [d8fd_pkg::COL_BITS-1:0]    col_last;
	logic [d8fd_pkg::ROW_BITS-1:0]    row_last;
	logic                             last_col;
	logic                             last_row;
	logic                             cfg_hit;

	logic              valid_s1;
	d8fd_pkg::meta_t   meta_s1;
	d8fd_pkg::elev_t   elev_s1;
	d8fd_pkg::elev_t   upper_rd;
	d8fd_pkg::elev_t   middle_rd;

	always_comb begin
		if (frame_width_q < d8fd_pkg::FWIDTH_BITS'(2)) begin
			col_last = d8fd_pkg::COL_BITS'(1);
		end else if (32'(frame_width_q) > 32'(d8fd_pkg::MAX_WIDTH)) begin
			col_last = d8fd_pkg::COL_BITS'(d8fd_pkg::MAX_WIDTH - 1);
		end else begin
			col_last = d8fd_pkg::COL_BITS'(frame_width_q - d8fd_pkg::FWIDTH_BITS'(1));
		end
		if (frame_height_q < d8fd_pkg::ROW_BITS'(2)) begin
			row_last = d8fd_pkg::ROW_BITS'(1);
		end else begin
			row_last = frame_height_q - d8fd_pkg::ROW_BITS'(1);
		end
	end

	assign last_col = (column_q == col_last);
	assign last_row = (row_q == row_last);
	assign cfg_hit  = write_enable &&
		(write_index == d8fd_pkg::REG_FRAME_WIDTH || write_index == d8fd_pkg::REG_FRAME_HEIGHT);

	assign result_count =
		d8fd_pkg::CNT_BITS'(row_q != '0 && column_q != '0) +
		d8fd_pkg::CNT_BITS'(row_q != '0 && last_col) +
		d8fd_pkg::CNT_BITS'(last_row && column_q != '0) +
		d8fd_pkg::CNT_BITS'(last_row && last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= d8fd_pkg::FWIDTH_BITS'(1024);
			frame_height_q <= d8fd_pkg::ROW_BITS'(1024);
		end else if (write_enable) begin
			case (write_index)
				d8fd_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= write_data[d8fd_pkg::FWIDTH_BITS-1:0];
				end
				d8fd_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= write_data[d8fd_pkg::ROW_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (cfg_hit) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (last_col) begin
				column_q <= '0;
				row_q    <= last_row ? '0 : row_q + d8fd_pkg::ROW_BITS'(1);
			end else begin
				column_q <= column_q + d8fd_pkg::COL_BITS'(1);
			end
		end
	end

	// a column is rewritten in the cycle after its read; the next read of it is >= 2 transactions later
	d8fd_ram #(
		.WIDTH(d8fd_pkg::ELEV_BITS),
		.DEPTH(d8fd_pkg::MAX_WIDTH)
	) u_upper (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(meta_s1.col),
		.wdata(middle_rd),
		.re   (accept),
		.raddr(column_q),
		.rdata(upper_rd)
	);

	d8fd_ram #(
		.WIDTH(d8fd_pkg::ELEV_BITS),
		.DEPTH(d8fd_pkg::MAX_WIDTH)
	) u_middle (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(meta_s1.col),
		.wdata(elev_s1),
		.re   (accept),
		.raddr(column_q),
		.rdata(middle_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= '{col: column_q, row: row_q, last_col: last_col, last_row: last_row};
			elev_s1 <= elevation;
		end
		meta_s2 <= meta_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r][0] <= window_q[r][1];
				window_q[r][1] <= window_q[r][2];
			end
			window_q[0][2] <= upper_rd;
			window_q[1][2] <= middle_rd;
			window_q[2][2] <= elev_s1;
		end
	end

endmodule

@@ sv/d8fd_lane.sv @@
module d8fd_lane (
	input  logic                          clk,
	input  d8fd_pkg::elev_t               center,
	input  d8fd_pkg::nbr_t                nb,
	input  logic [d8fd_pkg::NUM_DIRS-1:0] mask,
	output logic signed [3:0]             direction
);

	d8fd_pkg::drop_t drop_s3 [d8fd_pkg::NUM_DIRS];

	d8fd_pkg::drop_t orth_drop;
	d8fd_pkg::drop_t diag_drop;
	logic [1:0]      orth_dir;
	logic [1:0]      diag_dir;

	d8fd_pkg::drop_t orth_drop_s4;
	d8fd_pkg::drop_t diag_drop_s4;
	logic [1:0]      orth_dir_s4;
	logic [1:0]      diag_dir_s4;

	d8fd_pkg::drop_t                  orth_drop_s5;
	logic [d8fd_pkg::SCORE_BITS-1:0]  diag_score_s5;
	logic [1:0]                       orth_dir_s5;
	logic [1:0]                       diag_dir_s5;
	logic [d8fd_pkg::SCORE_BITS-1:0]  orth_score;

	// drop of a lower neighbor fits ELEV_BITS unsigned, so a wrapping subtract is exact
	always_ff @(posedge clk) begin
		for (int d = 0; d < d8fd_pkg::NUM_DIRS; d++) begin
			if (mask[d] && ($signed(nb[d]) < $signed(center))) begin
				drop_s3[d] <= d8fd_pkg::ELEV_BITS'(center - nb[d]);
			end else begin
				drop_s3[d] <= '0;
			end
		end
	end

	always_comb begin
		orth_drop = drop_s3[0];
		orth_dir  = 2'd0;
		diag_drop = drop_s3[4];
		diag_dir  = 2'd0;
		for (int d = 1; d < 4; d++) begin
			if (drop_s3[d] > orth_drop) begin
				orth_drop = drop_s3[d];
				orth_dir  = 2'(d);
			end
			if (drop_s3[d + 4] > diag_drop) begin
				diag_drop = drop_s3[d + 4];
				diag_dir  = 2'(d);
			end
		end
	end

	always_ff @(posedge clk) begin
		orth_drop_s4  <= orth_drop;
		orth_dir_s4   <= orth_dir;
		diag_drop_s4  <= diag_drop;
		diag_dir_s4   <= diag_dir;
		orth_drop_s5  <= orth_drop_s4;
		orth_dir_s5   <= orth_dir_s4;
		diag_dir_s5   <= diag_dir_s4;
		diag_score_s5 <= d8fd_pkg::SCORE_BITS'(diag_drop_s4) *
			d8fd_pkg::SCORE_BITS'(d8fd_pkg::DIAG_WEIGHT);
	end

	assign orth_score = {orth_drop_s5, {d8fd_pkg::WEIGHT_BITS{1'b0}}};

	// orthogonal directions precede diagonals, so a diagonal must be strictly steeper
	always_comb begin
		if (diag_score_s5 > orth_score) begin
			direction = d8fd_pkg::DIR_SE + $signed({2'b00, diag_dir_s5});
		end else if (orth_drop_s5 != '0) begin
			direction = d8fd_pkg::DIR_E + $signed({2'b00, orth_dir_s5});
		end else begin
			direction = d8fd_pkg::DIR_NONE;
		end
	end

endmodule

@@ sv/d8fd_queue.sv @@
module d8fd_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [d8fd_pkg::MAX_RESULTS-1:0] push,
	input  d8fd_pkg::result_t                push_data [d8fd_pkg::MAX_RESULTS],
	input  logic                             pop,
	output logic                             not_empty,
	output d8fd_pkg::result_t                head
);

	d8fd_pkg::result_t              mem_q [d8fd_pkg::QUEUE_DEPTH];
	logic [d8fd_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [d8fd_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [d8fd_pkg::QCNT_BITS-1:0] count_q;
	logic [d8fd_pkg::QPTR_BITS-1:0] slot [d8fd_pkg::MAX_RESULTS];
	logic [d8fd_pkg::QCNT_BITS-1:0] n_push;

	always_comb begin
		n_push = '0;
		for (int i = 0; i < d8fd_pkg::MAX_RESULTS; i++) begin
			slot[i] = wr_ptr_q + d8fd_pkg::QPTR_BITS'(n_push);
			n_push  = n_push + d8fd_pkg::QCNT_BITS'(push[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < d8fd_pkg::MAX_RESULTS; i++) begin
			if (push[i]) begin
				mem_q[slot[i]] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + d8fd_pkg::QPTR_BITS'(n_push);
			rd_ptr_q <= rd_ptr_q + d8fd_pkg::QPTR_BITS'(pop);
			count_q  <= count_q + n_push - d8fd_pkg::QCNT_BITS'(pop);
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

endmodule

@@ sv/d8_flow_direction.sv @@
// D8 flow direction over a streamed raster: one elevation transaction is taken per clock
// (row order, column fastest) and each pixel's steepest-descent direction comes out as a
// result transaction with its column, row and a frame_last flag. Results trail the input by
// one raster row plus a pipe (line-store RAM read, window shift, drop, group maximum,
// diagonal weighting, compare). A row-end input releases two results and the inputs of
// the last row release two more, so the frame's final pixel releases four; they drain
// through a 16-entry result queue at one per clock while result_stall is low. The input
// stalls only while more than 12 results are queued or in flight. With the result side
// taking one per clock the block sustains one pixel per clock everywhere but in a frame's
// last row, where each pixel releases two results and the input stalls on queue space. The two
// previous rows sit in two 4096x16 simple dual-port RAMs (one read and one write port),
// read and rewritten once per pixel; they need no clearing after reset. Writing either
// frame register restarts the frame at column 0, row 0.
module d8_flow_direction (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                write_enable,
	input  logic [d8fd_pkg::CFG_INDEX_BITS-1:0] write_index,
	input  logic [d8fd_pkg::CFG_DATA_BITS-1:0]  write_data,
	input  logic                                elevation_valid,
	output logic                                elevation_stall,
	input  logic signed [d8fd_pkg::ELEV_BITS-1:0] elevation,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [3:0]                   direction,
	output logic [d8fd_pkg::COL_BITS-1:0]       column,
	output logic [d8fd_pkg::ROW_BITS-1:0]       row,
	output logic                                frame_last
);

	logic                             accept;
	logic                             pop;
	logic [d8fd_pkg::CNT_BITS-1:0]    result_count;
	logic [d8fd_pkg::QCNT_BITS-1:0]   reserved_q;

	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;
	logic              valid_s5;
	d8fd_pkg::meta_t   meta_s2;
	d8fd_pkg::meta_t   meta_s3;
	d8fd_pkg::meta_t   meta_s4;
	d8fd_pkg::meta_t   meta_s5;
	d8fd_pkg::window_t window_q;

	logic                          x_ge2;
	logic                          y_ge2;
	logic [d8fd_pkg::NUM_LANES-1:0] has_n;
	logic [d8fd_pkg::NUM_LANES-1:0] has_s;
	logic [d8fd_pkg::NUM_LANES-1:0] has_w;
	logic [d8fd_pkg::NUM_LANES-1:0] has_e;

	d8fd_pkg::nbr_t                lane_nb   [d8fd_pkg::NUM_LANES];
	logic [d8fd_pkg::NUM_DIRS-1:0] lane_mask [d8fd_pkg::NUM_LANES];
	logic signed [3:0]             lane_dir  [d8fd_pkg::NUM_LANES];

	logic [d8fd_pkg::MAX_RESULTS-1:0] push;
	d8fd_pkg::result_t                push_data [d8fd_pkg::MAX_RESULTS];
	d8fd_pkg::result_t                head;
	logic [d8fd_pkg::COL_BITS-1:0]    col_prev;
	logic [d8fd_pkg::ROW_BITS-1:0]    row_prev;

	assign accept          = elevation_valid && !elevation_stall;
	assign pop             = result_valid && !result_stall;
	assign elevation_stall =
		reserved_q > d8fd_pkg::QCNT_BITS'(d8fd_pkg::QUEUE_DEPTH - d8fd_pkg::MAX_RESULTS);

	// results queued plus results still in the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else begin
			reserved_q <= reserved_q +
				(accept ? d8fd_pkg::QCNT_BITS'(result_count) : '0) -
				d8fd_pkg::QCNT_BITS'(pop);
		end
	end

	d8fd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_enable(write_enable),
		.write_index (write_index),
		.write_data  (write_data),
		.accept      (accept),
		.elevation   (elevation),
		.result_count(result_count),
		.valid_s2    (valid_s2),
		.meta_s2     (meta_s2),
		.window_q    (window_q)
	);

	assign x_ge2 = meta_s2.col >= d8fd_pkg::COL_BITS'(2);
	assign y_ge2 = meta_s2.row >= d8fd_pkg::ROW_BITS'(2);

	// lanes: center in the middle row (left, right), then in the newest row (left, right)
	assign has_n = {1'b1, 1'b1, y_ge2, y_ge2};
	assign has_s = 4'b0011;
	assign has_w = {1'b1, x_ge2, 1'b1, x_ge2};
	assign has_e = 4'b0101;

	for (genvar k = 0; k < d8fd_pkg::NUM_LANES; k++) begin : g_lane
		for (genvar d = 0; d < d8fd_pkg::NUM_DIRS; d++) begin : g_dir
			localparam int R = d8fd_pkg::CTR_ROW[k] + d8fd_pkg::DIR_DR[d];
			localparam int C = d8fd_pkg::CTR_COL[k] + d8fd_pkg::DIR_DC[d];
			if (R >= 0 && R <= 2 && C >= 0 && C <= 2) begin : g_in
				assign lane_nb[k][d] = window_q[R][C];
			end else begin : g_out
				assign lane_nb[k][d] = '0;
			end
			assign lane_mask[k][d] =
				(d8fd_pkg::DIR_DC[d] <= 0 || has_e[k]) &&
				(d8fd_pkg::DIR_DC[d] >= 0 || has_w[k]) &&
				(d8fd_pkg::DIR_DR[d] <= 0 || has_s[k]) &&
				(d8fd_pkg::DIR_DR[d] >= 0 || has_n[k]);
		end

		d8fd_lane u_lane (
			.clk      (clk),
			.center   (window_q[d8fd_pkg::CTR_ROW[k]][d8fd_pkg::CTR_COL[k]]),
			.nb       (lane_nb[k]),
			.mask     (lane_mask[k]),
			.direction(lane_dir[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
		meta_s5 <= meta_s4;
	end

	assign col_prev = meta_s5.col - d8fd_pkg::COL_BITS'(1);
	assign row_prev = meta_s5.row - d8fd_pkg::ROW_BITS'(1);

	always_comb begin
		push[0] = valid_s5 && meta_s5.row != '0 && meta_s5.col != '0;
		push[1] = valid_s5 && meta_s5.row != '0 && meta_s5.last_col;
		push[2] = valid_s5 && meta_s5.last_row && meta_s5.col != '0;
		push[3] = valid_s5 && meta_s5.last_row && meta_s5.last_col;
		push_data[0] = '{direction: lane_dir[0], column: col_prev, row: row_prev,
			frame_last: 1'b0};
		push_data[1] = '{direction: lane_dir[1], column: meta_s5.col, row: row_prev,
			frame_last: 1'b0};
		push_data[2] = '{direction: lane_dir[2], column: col_prev, row: meta_s5.row,
			frame_last: 1'b0};
		push_data[3] = '{direction: lane_dir[3], column: meta_s5.col, row: meta_s5.row,
			frame_last: 1'b1};
	end

	d8fd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.not_empty(result_valid),
		.head     (head)
	);

	assign direction  = head.direction;
	assign column     = head.column;
	assign row        = head.row;
	assign frame_last = head.frame_last;

endmodule

@@ sv/d8fd_checker.sv @@
`include "assert_macros.svh"

module d8fd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic signed [3:0]             direction,
	input logic [d8fd_pkg::COL_BITS-1:0] column,
	input logic [d8fd_pkg::ROW_BITS-1:0] row,
	input logic                          frame_last
);

	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(direction) && $stable(column) && $stable(row) && $stable(frame_last), "stalled result transaction changed")

	`ASSERT_IMPLIES(a_last_corner, clk, arst_n, result_valid && frame_last, row != '0 && column != '0, "frame_last on a pixel outside the bottom-right corner")

	`ASSERT_IMPLIES(a_north_in_frame, clk, arst_n, result_valid && (direction == d8fd_pkg::DIR_N || direction == d8fd_pkg::DIR_NE || direction == d8fd_pkg::DIR_NW), row != '0, "northward flow from the top row")

	`ASSERT_IMPLIES(a_west_in_frame, clk, arst_n, result_valid && (direction == d8fd_pkg::DIR_W || direction == d8fd_pkg::DIR_SW || direction == d8fd_pkg::DIR_NW), column != '0, "westward flow from the left column")

endmodule

bind d8_flow_direction d8fd_checker u_checker (.*);
